// ===== rtl/crr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Calcium reaction rates package
// Fixed-point constants, half-saturation constants, pipeline depths and
// configuration register codes shared by the rate pipeline.
// ----------------------------------------------------------------------------
package crr_pkg;

   localparam logic [20:0] ONE_Q = 21'h100000;

   localparam int unsigned DIV_STEPS  = 21;
   localparam int unsigned POW_STAGES = 3;
   localparam int unsigned HILL_LAT   = 2 * (DIV_STEPS + 1) + POW_STAGES;

   localparam logic [31:0] K_CA_ACT    = 32'd209715;
   localparam logic [31:0] K_IP3_ACT   = 32'd209715;
   localparam logic [31:0] K_CA_INACT  = 32'd209715;
   localparam logic [31:0] K_RYR_HALF  = 32'd1048576;
   localparam logic [31:0] K_PUMP_HALF = 32'd104858;
   localparam logic [31:0] K_DEG_HALF  = 32'd419430;

   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_IPR_RATE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK_RATE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RYR_RATE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PUMP_MAX  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLC_MAX   = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEG_MAX   = 8'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TAU   = 8'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_GAMMA = 8'd7;

   localparam logic [31:0] RST_ONE  = 32'd1048576;
   localparam logic [31:0] RST_ZERO = 32'd0;

endpackage
`default_nettype wire

// ===== rtl/calcium_reaction_rates.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Calcium reaction rates
// Per-node cytosol and ER calcium kinetics with IP3 signalling in Q12.20.
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_*           taken when start and not busy
//   result    rsp_valid, rsp_*             one cycle per result, no backpressure
//   csr       csr_valid, csr_ready, csr_*  write when valid and ready
//
// A request enters every cycle; busy is always low. Its result passes
// through one input register, the Hill fraction units (two 21-step
// dividers and three power stages) and the registered products, sums
// and clipping. Reset clears the valid pipeline and sets the
// configuration registers to their defaults. Nothing stalls inside the
// pipeline.
// ----------------------------------------------------------------------------
module calcium_reaction_rates #(
   parameter logic [31:0] K_CA_ACT    = crr_pkg::K_CA_ACT,
   parameter logic [31:0] K_IP3_ACT   = crr_pkg::K_IP3_ACT,
   parameter logic [31:0] K_CA_INACT  = crr_pkg::K_CA_INACT,
   parameter logic [31:0] K_RYR_HALF  = crr_pkg::K_RYR_HALF,
   parameter logic [31:0] K_PUMP_HALF = crr_pkg::K_PUMP_HALF,
   parameter logic [31:0] K_DEG_HALF  = crr_pkg::K_DEG_HALF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [31:0]                    req_cyto_ca,
   input  logic [31:0]                    req_ip3_level,
   input  logic [20:0]                    req_gate_h,
   input  logic [31:0]                    req_er_ca,
   input  logic [20:0]                    req_ipr_factor,
   input  logic [20:0]                    req_plc_factor,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_rate_cyto_ca,
   output logic signed [31:0]             rsp_rate_ip3,
   output logic signed [31:0]             rsp_rate_gate_h,
   output logic signed [31:0]             rsp_rate_er_ca,
   output logic                           rsp_saturated,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [crr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);
   import crr_pkg::*;

   localparam int unsigned TAIL     = 12;
   localparam int unsigned PIPE_LEN = HILL_LAT + TAIL + 1;

   typedef struct packed {
      logic [32:0] ipr_prod;
      logic [32:0] plc_prod;
      logic [43:0] dmip;
      logic [31:0] diff_mag;
      logic        diff_neg;
      logic [20:0] gate_h;
   } side_type;

   logic [31:0] ipr_rate_ff, leak_rate_ff, ryr_rate_ff, pump_max_ff;
   logic [31:0] plc_max_ff, deg_max_ff, inv_tau_ff, inv_gamma_ff;

   logic [PIPE_LEN-1:0] vld_ff;

   logic [31:0] c0_ff, ip0_ff, ce0_ff;
   logic [20:0] h0_ff, iprf0_ff, plcf0_ff;

   logic [20:0] phi_c, phi_p, hinf, pryr, pump_f, phi3;

   side_type    side_in;
   side_type    side_ff [0:HILL_LAT-1];
   side_type    sd;
   logic [52:0] ipr_full, plc_full;
   logic [63:0] dm_full;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ipr_rate_ff  <= RST_ONE;
         leak_rate_ff <= RST_ZERO;
         ryr_rate_ff  <= RST_ZERO;
         pump_max_ff  <= RST_ZERO;
         plc_max_ff   <= RST_ZERO;
         deg_max_ff   <= RST_ZERO;
         inv_tau_ff   <= RST_ONE;
         inv_gamma_ff <= RST_ONE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IPR_RATE:  ipr_rate_ff  <= csr_wdata;
            CSR_LEAK_RATE: leak_rate_ff <= csr_wdata;
            CSR_RYR_RATE:  ryr_rate_ff  <= csr_wdata;
            CSR_PUMP_MAX:  pump_max_ff  <= csr_wdata;
            CSR_PLC_MAX:   plc_max_ff   <= csr_wdata;
            CSR_DEG_MAX:   deg_max_ff   <= csr_wdata;
            CSR_INV_TAU:   inv_tau_ff   <= csr_wdata;
            CSR_INV_GAMMA: inv_gamma_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], start & ~busy};
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         c0_ff    <= req_cyto_ca;
         ip0_ff   <= req_ip3_level;
         h0_ff    <= req_gate_h;
         ce0_ff   <= req_er_ca;
         iprf0_ff <= req_ipr_factor;
         plcf0_ff <= req_plc_factor;
      end
   end

   crr_hill #(.K_HALF(K_CA_ACT), .POWER(3), .COMPLEMENT(1'b0)) u_hill_ca_act (
      .clock(clock), .x(c0_ff), .frac(phi_c));
   crr_hill #(.K_HALF(K_IP3_ACT), .POWER(4), .COMPLEMENT(1'b0)) u_hill_ip3 (
      .clock(clock), .x(ip0_ff), .frac(phi_p));
   crr_hill #(.K_HALF(K_CA_INACT), .POWER(2), .COMPLEMENT(1'b1)) u_hill_inact (
      .clock(clock), .x(c0_ff), .frac(hinf));
   crr_hill #(.K_HALF(K_RYR_HALF), .POWER(2), .COMPLEMENT(1'b0)) u_hill_ryr (
      .clock(clock), .x(c0_ff), .frac(pryr));
   crr_hill #(.K_HALF(K_PUMP_HALF), .POWER(2), .COMPLEMENT(1'b0)) u_hill_pump (
      .clock(clock), .x(c0_ff), .frac(pump_f));
   crr_hill #(.K_HALF(K_DEG_HALF), .POWER(2), .COMPLEMENT(1'b0)) u_hill_deg (
      .clock(clock), .x(c0_ff), .frac(phi3));

   assign ipr_full = 53'(iprf0_ff) * 53'(ipr_rate_ff);
   assign plc_full = 53'(plcf0_ff) * 53'(plc_max_ff);
   assign dm_full  = 64'(deg_max_ff) * 64'(ip0_ff);

   always_comb begin
      side_in.ipr_prod = ipr_full[52:20];
      side_in.plc_prod = plc_full[52:20];
      side_in.dmip     = dm_full[63:20];
      side_in.diff_neg = (ce0_ff < c0_ff);
      side_in.diff_mag = side_in.diff_neg ? (c0_ff - ce0_ff) : (ce0_ff - c0_ff);
      side_in.gate_h   = h0_ff;
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < HILL_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign sd = side_ff[HILL_LAT-1];

   logic [41:0] pp_full;
   logic [52:0] ryr_full, js_full;
   logic [20:0] pp_t1_ff, h_t1_ff, hmag_t1_ff;
   logic        hneg_t1_ff;
   logic [31:0] ryr_t1_ff, js_t1_ff;
   logic [42:0] dlo_t1_ff, dhi_t1_ff;
   logic [32:0] ipr_t1_ff, plc_t1_ff;
   logic [31:0] dmag_t1_ff;
   logic        dneg_t1_ff;

   assign pp_full  = 42'(phi_c) * 42'(phi_p);
   assign ryr_full = 53'(ryr_rate_ff) * 53'(pryr);
   assign js_full  = 53'(pump_max_ff) * 53'(pump_f);

   always_ff @(posedge clock) begin
      pp_t1_ff   <= pp_full[40:20];
      ryr_t1_ff  <= ryr_full[51:20];
      js_t1_ff   <= js_full[51:20];
      dlo_t1_ff  <= 43'(sd.dmip[21:0]) * 43'(phi3);
      dhi_t1_ff  <= 43'(sd.dmip[43:22]) * 43'(phi3);
      hneg_t1_ff <= (sd.gate_h > hinf);
      hmag_t1_ff <= (sd.gate_h > hinf) ? (sd.gate_h - hinf) : (hinf - sd.gate_h);
      h_t1_ff    <= sd.gate_h;
      ipr_t1_ff  <= sd.ipr_prod;
      plc_t1_ff  <= sd.plc_prod;
      dmag_t1_ff <= sd.diff_mag;
      dneg_t1_ff <= sd.diff_neg;
   end

   logic [41:0] po_full;
   logic [64:0] deg_sum;
   logic [52:0] rh_full;
   logic [20:0] po_t2_ff;
   logic [43:0] deg_t2_ff;
   logic [32:0] rhm_t2_ff, ipr_t2_ff, plc_t2_ff;
   logic        hneg_t2_ff, dneg_t2_ff;
   logic [31:0] ryr_t2_ff, js_t2_ff, dmag_t2_ff;

   assign po_full = 42'(pp_t1_ff) * 42'(h_t1_ff);
   assign deg_sum = {dhi_t1_ff[42:0], 22'b0} + 65'(dlo_t1_ff);
   assign rh_full = 53'(hmag_t1_ff) * 53'(inv_tau_ff);

   always_ff @(posedge clock) begin
      po_t2_ff   <= po_full[40:20];
      deg_t2_ff  <= deg_sum[63:20];
      rhm_t2_ff  <= rh_full[52:20];
      hneg_t2_ff <= hneg_t1_ff;
      ipr_t2_ff  <= ipr_t1_ff;
      plc_t2_ff  <= plc_t1_ff;
      ryr_t2_ff  <= ryr_t1_ff;
      js_t2_ff   <= js_t1_ff;
      dmag_t2_ff <= dmag_t1_ff;
      dneg_t2_ff <= dneg_t1_ff;
   end

   logic [53:0]        jipr_full;
   logic [33:0]        jipr_t3_ff;
   logic signed [45:0] rip3_t3_ff;
   logic signed [33:0] rh_t3_ff;
   logic [31:0]        ryr_t3_ff, js_t3_ff, dmag_t3_ff;
   logic               dneg_t3_ff;

   assign jipr_full = 54'(ipr_t2_ff) * 54'(po_t2_ff);

   always_ff @(posedge clock) begin
      jipr_t3_ff <= jipr_full[53:20];
      rip3_t3_ff <= $signed({13'b0, plc_t2_ff}) - $signed({2'b0, deg_t2_ff});
      rh_t3_ff   <= hneg_t2_ff ? -$signed({1'b0, rhm_t2_ff}) : $signed({1'b0, rhm_t2_ff});
      ryr_t3_ff  <= ryr_t2_ff;
      js_t3_ff   <= js_t2_ff;
      dmag_t3_ff <= dmag_t2_ff;
      dneg_t3_ff <= dneg_t2_ff;
   end

   logic [34:0] perm_t4_ff;
   logic [31:0] js_t4_ff, dmag_t4_ff;
   logic        dneg_t4_ff;

   always_ff @(posedge clock) begin
      perm_t4_ff <= {1'b0, jipr_t3_ff} + {3'b0, leak_rate_ff} + {3'b0, ryr_t3_ff};
      js_t4_ff   <= js_t3_ff;
      dmag_t4_ff <= dmag_t3_ff;
      dneg_t4_ff <= dneg_t3_ff;
   end

   logic [50:0] qa_t5_ff, qb_t5_ff;
   logic [31:0] js_t5_ff;
   logic        dneg_t5_ff;

   always_ff @(posedge clock) begin
      qa_t5_ff   <= 51'(perm_t4_ff) * 51'(dmag_t4_ff[15:0]);
      qb_t5_ff   <= 51'(perm_t4_ff) * 51'(dmag_t4_ff[31:16]);
      js_t5_ff   <= js_t4_ff;
      dneg_t5_ff <= dneg_t4_ff;
   end

   logic [66:0] q_sum;
   logic [46:0] qm_t6_ff;
   logic [31:0] js_t6_ff;
   logic        dneg_t6_ff;

   assign q_sum = {qb_t5_ff, 16'b0} + 67'(qa_t5_ff);

   always_ff @(posedge clock) begin
      qm_t6_ff   <= q_sum[66:20];
      js_t6_ff   <= js_t5_ff;
      dneg_t6_ff <= dneg_t5_ff;
   end

   logic signed [48:0] qs_in, erc_in;
   logic signed [48:0] erc_t7_ff;

   always_comb begin
      qs_in  = $signed({2'b0, qm_t6_ff});
      erc_in = (dneg_t6_ff ? -qs_in : qs_in) - $signed({17'b0, js_t6_ff});
   end

   always_ff @(posedge clock) begin
      erc_t7_ff <= erc_in;
   end

   logic [48:0] erc_neg_in;
   logic [47:0] emag_t8_ff;
   logic        eneg_t8_ff;

   assign erc_neg_in = 49'(-erc_t7_ff);

   always_ff @(posedge clock) begin
      eneg_t8_ff <= erc_t7_ff[48];
      emag_t8_ff <= erc_t7_ff[48] ? erc_neg_in[47:0] : erc_t7_ff[47:0];
   end

   logic [55:0] ra_t9_ff, rb_t9_ff;
   logic        eneg_t9_ff;

   always_ff @(posedge clock) begin
      ra_t9_ff   <= 56'(emag_t8_ff[23:0]) * 56'(inv_gamma_ff);
      rb_t9_ff   <= 56'(emag_t8_ff[47:24]) * 56'(inv_gamma_ff);
      eneg_t9_ff <= eneg_t8_ff;
   end

   logic [79:0] r_sum;
   logic [59:0] rm_t10_ff;
   logic        eneg_t10_ff;

   assign r_sum = {rb_t9_ff, 24'b0} + 80'(ra_t9_ff);

   always_ff @(posedge clock) begin
      rm_t10_ff   <= r_sum[79:20];
      eneg_t10_ff <= eneg_t9_ff;
   end

   logic signed [60:0] rer_t11_ff;
   logic signed [45:0] rip3_dl_ff [0:7];
   logic signed [33:0] rh_dl_ff   [0:7];
   logic signed [48:0] erc_dl_ff  [0:3];

   always_ff @(posedge clock) begin
      rer_t11_ff <= eneg_t10_ff ? $signed({1'b0, rm_t10_ff}) : -$signed({1'b0, rm_t10_ff});
      rip3_dl_ff[0] <= rip3_t3_ff;
      rh_dl_ff[0]   <= rh_t3_ff;
      for (int i = 1; i < 8; i++) begin
         rip3_dl_ff[i] <= rip3_dl_ff[i-1];
         rh_dl_ff[i]   <= rh_dl_ff[i-1];
      end
      erc_dl_ff[0] <= erc_t7_ff;
      for (int i = 1; i < 4; i++) begin
         erc_dl_ff[i] <= erc_dl_ff[i-1];
      end
   end

   function automatic logic [32:0] clip_q(input logic signed [63:0] v);
      logic [32:0] r;
      if (v > 64'sd2147483647) begin
         r = {1'b1, 32'h7FFFFFFF};
      end else if (v < -64'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

   logic [32:0] cl_erc_in, cl_rip3_in, cl_rh_in, cl_rer_in;
   logic signed [31:0] rate_cyto_ff, rate_ip3_ff, rate_h_ff, rate_er_ff;
   logic               sat_ff;

   always_comb begin
      cl_erc_in  = clip_q(64'(erc_dl_ff[3]));
      cl_rip3_in = clip_q(64'(rip3_dl_ff[7]));
      cl_rh_in   = clip_q(64'(rh_dl_ff[7]));
      cl_rer_in  = clip_q(64'(rer_t11_ff));
   end

   always_ff @(posedge clock) begin
      rate_cyto_ff <= $signed(cl_erc_in[31:0]);
      rate_ip3_ff  <= $signed(cl_rip3_in[31:0]);
      rate_h_ff    <= $signed(cl_rh_in[31:0]);
      rate_er_ff   <= $signed(cl_rer_in[31:0]);
      sat_ff       <= cl_erc_in[32] | cl_rip3_in[32] | cl_rh_in[32] | cl_rer_in[32];
   end

   assign rsp_valid        = vld_ff[PIPE_LEN-1];
   assign rsp_rate_cyto_ca = rate_cyto_ff;
   assign rsp_rate_ip3     = rate_ip3_ff;
   assign rsp_rate_gate_h  = rate_h_ff;
   assign rsp_rate_er_ca   = rate_er_ff;
   assign rsp_saturated    = sat_ff;

endmodule
`default_nettype wire

// ===== rtl/crr_hill.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hill fraction pipeline
// Computes x^n/(K^n+x^n), or its complement, in Q.20 with two bit-per-stage
// restoring dividers and a short chain of registered power multiplies.
// ----------------------------------------------------------------------------
module crr_hill #(
   parameter logic [31:0] K_HALF     = crr_pkg::K_CA_ACT,
   parameter int unsigned POWER      = 2,
   parameter bit          COMPLEMENT = 1'b0
) (
   input  logic        clock,
   input  logic [31:0] x,
   output logic [20:0] frac
);
   import crr_pkg::*;

   logic [32:0] d1_rem_ff [0:DIV_STEPS];
   logic [31:0] d1_den_ff [0:DIV_STEPS];
   logic [20:0] d1_q_ff   [0:DIV_STEPS];
   logic        d1_xge_ff [0:DIV_STEPS];

   logic [20:0] pw_src_p   [0:POW_STAGES];
   logic [20:0] pw_src_q   [0:POW_STAGES];
   logic        pw_src_xge [0:POW_STAGES];
   logic [20:0] pw_p_ff    [1:POW_STAGES];
   logic [20:0] pw_q_ff    [1:POW_STAGES];
   logic        pw_xge_ff  [1:POW_STAGES];

   logic [22:0] d2_rem_ff [0:DIV_STEPS];
   logic [21:0] d2_den_ff [0:DIV_STEPS];
   logic [20:0] d2_q_ff   [0:DIV_STEPS];

   logic        xge_in;
   logic [20:0] num_in;
   logic [21:0] sum_in;

   assign xge_in = (x >= K_HALF);

   always_ff @(posedge clock) begin
      d1_xge_ff[0] <= xge_in;
      d1_rem_ff[0] <= {1'b0, (xge_in ? K_HALF : x)};
      d1_den_ff[0] <= xge_in ? x : K_HALF;
      d1_q_ff[0]   <= '0;
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div1
      logic [32:0] t;
      logic        ge;
      assign t  = (j == 1) ? d1_rem_ff[j-1] : {d1_rem_ff[j-1][31:0], 1'b0};
      assign ge = (t >= {1'b0, d1_den_ff[j-1]});
      always_ff @(posedge clock) begin
         d1_rem_ff[j] <= ge ? (t - {1'b0, d1_den_ff[j-1]}) : t;
         d1_den_ff[j] <= d1_den_ff[j-1];
         d1_q_ff[j]   <= {d1_q_ff[j-1][19:0], ge};
         d1_xge_ff[j] <= d1_xge_ff[j-1];
      end
   end

   assign pw_src_p[0]   = d1_q_ff[DIV_STEPS];
   assign pw_src_q[0]   = d1_q_ff[DIV_STEPS];
   assign pw_src_xge[0] = d1_xge_ff[DIV_STEPS];

   for (genvar i = 1; i <= POW_STAGES; i++) begin : g_pow
      logic [41:0] prod;
      assign prod = 42'(pw_src_p[i-1]) * 42'(pw_src_q[i-1]);
      always_ff @(posedge clock) begin
         pw_p_ff[i]   <= (i < POWER) ? prod[40:20] : pw_src_p[i-1];
         pw_q_ff[i]   <= pw_src_q[i-1];
         pw_xge_ff[i] <= pw_src_xge[i-1];
      end
      assign pw_src_p[i]   = pw_p_ff[i];
      assign pw_src_q[i]   = pw_q_ff[i];
      assign pw_src_xge[i] = pw_xge_ff[i];
   end

   always_comb begin
      if (COMPLEMENT) begin
         num_in = pw_src_xge[POW_STAGES] ? pw_src_p[POW_STAGES] : ONE_Q;
      end else begin
         num_in = pw_src_xge[POW_STAGES] ? ONE_Q : pw_src_p[POW_STAGES];
      end
      sum_in = {1'b0, pw_src_p[POW_STAGES]} + {1'b0, ONE_Q};
   end

   always_ff @(posedge clock) begin
      d2_rem_ff[0] <= {2'b00, num_in};
      d2_den_ff[0] <= sum_in;
      d2_q_ff[0]   <= '0;
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div2
      logic [22:0] t;
      logic        ge;
      assign t  = (j == 1) ? d2_rem_ff[j-1] : {d2_rem_ff[j-1][21:0], 1'b0};
      assign ge = (t >= {1'b0, d2_den_ff[j-1]});
      always_ff @(posedge clock) begin
         d2_rem_ff[j] <= ge ? (t - {1'b0, d2_den_ff[j-1]}) : t;
         d2_den_ff[j] <= d2_den_ff[j-1];
         d2_q_ff[j]   <= {d2_q_ff[j-1][19:0], ge};
      end
   end

   assign frac = d2_q_ff[DIV_STEPS];

endmodule
`default_nettype wire
